[sv/fbfl_pkg.sv]
// Shared types and constants for the fixed-block free-list manager.
// No dependencies; every other file imports this package.
`default_nettype none

package fbfl_pkg;

    localparam int BLK_W = 10;    // block number width
    localparam int CNT_W = 11;    // count width, holds 0..1024
    localparam int BLK_SPAN = 1 << BLK_W;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_READ     = 2'd1,
        OP_DELETE   = 2'd2,
        OP_GET_FREE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_BLOCK = 2'd1,
        ST_IS_FREE  = 2'd2,
        ST_NO_FREE  = 2'd3
    } status_t;

    // Broadcast from the control logic to every cell of the list.
    typedef struct packed {
        logic             remove;   // close the gap at pos
        logic             append;   // load the cell at fill
        logic [BLK_W-1:0] pos;      // position of the matching entry
        logic [CNT_W-1:0] fill;     // entries in use
    } cell_ctl_t;

endpackage

`default_nettype wire

[sv/fbfl_cell.sv]
// One free-list cell: holds one entry, compares it against the key and
// takes its right neighbor's entry when its own or an earlier entry is removed. Uses fbfl_pkg.
`default_nettype none

module fbfl_cell #(
    parameter int INDEX = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmp_en,
    input  logic [fbfl_pkg::BLK_W-1:0]   key,
    input  fbfl_pkg::cell_ctl_t          ctl,
    input  logic [fbfl_pkg::BLK_W-1:0]   load_value,
    input  logic [fbfl_pkg::BLK_W-1:0]   neighbor,
    output logic [fbfl_pkg::BLK_W-1:0]   value,
    output logic                         hit
);
    import fbfl_pkg::*;

    logic [BLK_W-1:0] value_reg;
    logic             hit_reg;
    logic             in_use;

    assign in_use = CNT_W'(INDEX) < ctl.fill;

    always_ff @(posedge clk)
    begin
        if (ctl.append && (ctl.fill == CNT_W'(INDEX)))
        begin
            value_reg <= load_value;
        end
        else if (ctl.remove && (BLK_W'(INDEX) >= ctl.pos))
        begin
            value_reg <= neighbor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmp_en)
        begin
            hit_reg <= in_use && (value_reg == key);
        end
    end

    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

[sv/fbfl_encode.sv]
// Turns the row of cell match flags (at most one set) into a position
// and an any-match flag. Uses fbfl_pkg.
`default_nettype none

module fbfl_encode #(
    parameter int CELLS = 1024
) (
    input  logic [CELLS-1:0]             hits,
    output logic [fbfl_pkg::BLK_W-1:0]   pos,
    output logic                         any
);
    import fbfl_pkg::*;

    // OR of the indexes of the set flags; exact since the flags are one-hot.
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < CELLS; i++)
        begin
            if (hits[i])
            begin
                pos = pos | BLK_W'(i);
            end
        end
    end

    assign any = |hits;

endmodule

`default_nettype wire

[sv/fixed_block_free_list_manager.sv]
// Top level of the fixed-block free-list manager: counters, operation
// control, result register and the row of free-list cells. Uses fbfl_pkg,
// fbfl_cell and fbfl_encode.
//
//   channel | direction | handshake           | fields
//   req     | in        | req_valid/req_stall | kind, block_index
//   rsp     | out       | rsp_valid/rsp_stall | status, free_block, was_free,
//           |           |                     | used_count, free_count
//
// On the transfer every cell compares its entry with block_index; then the
// cell row shifts or loads and the result register is written. req_stall is
// high from the transfer until that write, so a new item is taken only after
// the last one completes. If the result register still holds an untaken
// result, the item waits. Reset clears both counts; cell contents are not reset.
`default_nettype none

module fixed_block_free_list_manager #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  fbfl_pkg::kind_t              kind,
    input  logic [fbfl_pkg::BLK_W-1:0]   block_index,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output fbfl_pkg::status_t            status,
    output logic [fbfl_pkg::BLK_W-1:0]   free_block,
    output logic                         was_free,
    output logic [fbfl_pkg::CNT_W-1:0]   used_count,
    output logic [fbfl_pkg::CNT_W-1:0]   free_count
);
    import fbfl_pkg::*;

    // Free entries are distinct block numbers, so the list never exceeds BLK_SPAN.
    localparam int CELLS = (MAX_BLOCKS < BLK_SPAN) ? MAX_BLOCKS : BLK_SPAN;

    logic             busy_reg, busy_next;
    kind_t            kind_reg;
    logic [BLK_W-1:0] blk_reg;
    logic [CNT_W-1:0] block_total_reg, block_total_next;
    logic [CNT_W-1:0] free_total_reg, free_total_next;

    logic             rsp_valid_reg, rsp_valid_next;
    status_t          status_reg, status_next;
    logic [BLK_W-1:0] free_block_reg, free_block_next;
    logic             was_free_reg, was_free_next;

    logic             take;
    logic             go;
    logic [CELLS-1:0] hits;
    logic [BLK_W-1:0] cell_value [CELLS];
    logic [BLK_W-1:0] hit_pos;
    logic             any_hit;
    cell_ctl_t        ctl;

    logic [CNT_W-1:0] blk_ext;
    logic             exists;
    logic             at_end;
    logic             full;
    logic             wr_err;
    logic             room;

    assign take = req_valid && !busy_reg;
    assign go   = busy_reg && (!rsp_valid_reg || !rsp_stall);

    assign blk_ext = {1'b0, blk_reg};
    assign exists  = blk_ext < block_total_reg;
    assign at_end  = blk_ext == block_total_reg;
    assign full    = 32'(block_total_reg) >= 32'(MAX_BLOCKS);
    assign wr_err  = (blk_ext > block_total_reg) || (at_end && full);
    assign room    = 32'(free_total_reg) < 32'(CELLS);

    always_comb
    begin
        ctl.remove = go && (kind_reg == OP_WRITE) && !wr_err && any_hit;
        ctl.append = go && (kind_reg == OP_DELETE) && exists && !any_hit && room;
        ctl.pos    = hit_pos;
        ctl.fill   = free_total_reg;
    end

    fbfl_encode #(
        .CELLS (CELLS)
    ) u_encode (
        .hits (hits),
        .pos  (hit_pos),
        .any  (any_hit)
    );

    for (genvar g = 0; g < CELLS; g++)
    begin : g_cell
        logic [BLK_W-1:0] right;

        if (g == CELLS - 1)
        begin : g_last
            assign right = cell_value[g];
        end
        else
        begin : g_mid
            assign right = cell_value[g + 1];
        end

        fbfl_cell #(
            .INDEX (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmp_en     (take),
            .key        (block_index),
            .ctl        (ctl),
            .load_value (blk_reg),
            .neighbor   (right),
            .value      (cell_value[g]),
            .hit        (hits[g])
        );
    end

    always_comb
    begin
        busy_next        = busy_reg;
        block_total_next = block_total_reg;
        free_total_next  = free_total_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        status_next      = status_reg;
        free_block_next  = free_block_reg;
        was_free_next    = was_free_reg;

        if (take)
        begin
            busy_next = 1'b1;
        end

        if (go)
        begin
            busy_next       = 1'b0;
            rsp_valid_next  = 1'b1;
            status_next     = ST_OK;
            free_block_next = '0;
            was_free_next   = any_hit && (kind_reg != OP_GET_FREE);

            unique case (kind_reg)
                OP_WRITE:
                begin
                    if (wr_err)
                    begin
                        status_next = ST_NO_BLOCK;
                    end
                    else
                    begin
                        if (any_hit)
                        begin
                            free_total_next = free_total_reg - CNT_W'(1);
                        end
                        if (at_end)
                        begin
                            block_total_next = block_total_reg + CNT_W'(1);
                        end
                    end
                end
                OP_READ:
                begin
                    if (!exists)
                    begin
                        status_next = ST_NO_BLOCK;
                    end
                    else if (any_hit)
                    begin
                        status_next = ST_IS_FREE;
                    end
                end
                OP_DELETE:
                begin
                    if (!exists)
                    begin
                        status_next = ST_NO_BLOCK;
                    end
                    else if (any_hit)
                    begin
                        status_next = ST_IS_FREE;
                    end
                    else if (room)
                    begin
                        free_total_next = free_total_reg + CNT_W'(1);
                    end
                end
                OP_GET_FREE:
                begin
                    if (free_total_reg != '0)
                    begin
                        free_block_next = cell_value[0];
                    end
                    else
                    begin
                        status_next = ST_NO_FREE;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            block_total_reg <= '0;
            free_total_reg  <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            block_total_reg <= block_total_next;
            free_total_reg  <= free_total_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= kind;
            blk_reg  <= block_index;
        end
        status_reg     <= status_next;
        free_block_reg <= free_block_next;
        was_free_reg   <= was_free_next;
    end

    assign req_stall  = busy_reg;
    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign free_block = free_block_reg;
    assign was_free   = was_free_reg;
    assign used_count = block_total_reg;
    assign free_count = free_total_reg;

`ifndef SYNTHESIS
    // Every free entry is a distinct existing block.
    a_free_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        free_total_reg <= block_total_reg)
        else $error("free count exceeds used count");

    // Distinct entries: a compare never matches more than one cell.
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hits))
        else $error("more than one cell matched");

    // Counts only move when an item completes.
    a_count_move: assert property (@(posedge clk) disable iff (!rst_n)
        ((free_total_reg != $past(free_total_reg)) ||
         (block_total_reg != $past(block_total_reg))) |-> $past(go))
        else $error("count changed without an item completing");

    // A completing item always leaves a result.
    a_go_result: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> rsp_valid_reg)
        else $error("completed item left no result");
`endif

endmodule

`default_nettype wire

[tb/fbfl_checker.sv]
// Checker for the fixed-block free-list manager: watches both channels,
// predicts every result from its own copy of the free list and block count,
// and compares. Depends on fbfl_pkg.
module fbfl_checker #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic                         req_stall,
    input  fbfl_pkg::kind_t              kind,
    input  logic [fbfl_pkg::BLK_W-1:0]   block_index,
    input  logic                         rsp_valid,
    input  logic                         rsp_stall,
    input  fbfl_pkg::status_t            status,
    input  logic [fbfl_pkg::BLK_W-1:0]   free_block,
    input  logic                         was_free,
    input  logic [fbfl_pkg::CNT_W-1:0]   used_count,
    input  logic [fbfl_pkg::CNT_W-1:0]   free_count,
    output int                           errors,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fbfl_pkg::*;

    typedef struct packed {
        status_t          st;
        logic [BLK_W-1:0] fblk;
        logic             wasf;
        logic [CNT_W-1:0] used;
        logic [CNT_W-1:0] nfree;
    } alloc_result_t;

    logic [BLK_W-1:0] freed_q[$];     // free list, oldest first
    int               blocks_used;
    alloc_result_t    answer_q[$];     // predicted results not yet seen
    alloc_result_t    got;
    alloc_result_t    want;

    function automatic alloc_result_t apply_alloc_op(input kind_t k,
                                                     input logic [BLK_W-1:0] b);
        alloc_result_t r;
        int            pos;
        int            blk_n;
        r = '0;
        r.st = ST_OK;
        pos = -1;
        blk_n = b;
        if (k != OP_GET_FREE)
        begin
            foreach (freed_q[i])
                if (pos < 0 && freed_q[i] == b)
                    pos = i;
        end
        r.wasf = (pos >= 0);
        case (k)
            OP_WRITE:
            begin
                if (blk_n > blocks_used ||
                    (blk_n == blocks_used && blocks_used >= MAX_BLOCKS))
                    r.st = ST_NO_BLOCK;
                else
                begin
                    // closing the gap keeps the remaining order
                    if (pos >= 0)
                        freed_q.delete(pos);
                    if (blk_n == blocks_used)
                        blocks_used++;
                end
            end
            OP_READ:
            begin
                if (blk_n >= blocks_used)
                    r.st = ST_NO_BLOCK;
                else if (pos >= 0)
                    r.st = ST_IS_FREE;
            end
            OP_DELETE:
            begin
                if (blk_n >= blocks_used)
                    r.st = ST_NO_BLOCK;
                else if (pos >= 0)
                    r.st = ST_IS_FREE;
                else if (freed_q.size() < MAX_BLOCKS)
                    freed_q.insert(freed_q.size(), b);
            end
            default:
            begin
                if (freed_q.size() > 0)
                    r.fblk = freed_q[0];
                else
                    r.st = ST_NO_FREE;
            end
        endcase
        r.used = blocks_used[CNT_W-1:0];
        r.nfree = CNT_W'(freed_q.size());
        return r;
    endfunction

    task automatic log_mismatch(input string why, input alloc_result_t w,
                                input alloc_result_t g);
        string exp_s;
        string got_s;
        errors++;
        if (errors <= 10)
        begin
            exp_s = $sformatf("st=%0d fb=%0d wf=%0b used=%0d free=%0d",
                              w.st, w.fblk, w.wasf, w.used, w.nfree);
            got_s = $sformatf("st=%0d fb=%0d wf=%0b used=%0d free=%0d",
                              g.st, g.fblk, g.wasf, g.used, g.nfree);
            $display("%0t: %s: exp %s | got %s", $realtime, why, exp_s, got_s);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freed_q.delete();
            answer_q.delete();
            blocks_used = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got.st = status;
                got.fblk = free_block;
                got.wasf = was_free;
                got.used = used_count;
                got.nfree = free_count;
                if (answer_q.size() == 0)
                    log_mismatch("result with nothing outstanding", '0, got);
                else
                begin
                    want = answer_q.pop_front();
                    if (got !== want)
                        log_mismatch("result mismatch", want, got);
                end
            end
            if (req_valid && !req_stall)
                answer_q.insert(answer_q.size(), apply_alloc_op(kind, block_index));
        end
        pending = answer_q.size();
    end

endmodule

[tb/tb.sv]
// Testbench top for the fixed-block free-list manager: clock, reset,
// request stimulus, response pacing and the verdict.
// Depends on fbfl_pkg, fixed_block_free_list_manager and fbfl_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fbfl_pkg::*;

    localparam int MAX_BLOCKS  = 1024;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 1750;
    localparam int HOLD_CYCLES = 250;
    localparam int N_DIRECTED  = 25;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    kind_t            kind;
    logic [BLK_W-1:0] block_index;
    logic             rsp_valid;
    status_t          status;
    logic [BLK_W-1:0] free_block;
    logic             was_free;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] free_count;
    logic             pace_stall;
    logic             hold_rsp;
    wire              rsp_stall = pace_stall | hold_rsp;

    int               errors;
    int               pending;
    bit               hold_req;
    bit               tx_busy;
    bit               rx_busy;
    int               n_sent;
    int               tx_used;        // blocks in the store, as issued
    int               tx_free_q[$];   // free list, as issued

    fixed_block_free_list_manager #(.MAX_BLOCKS(MAX_BLOCKS)) dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .kind(kind), .block_index(block_index),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .status(status), .free_block(free_block), .was_free(was_free),
        .used_count(used_count), .free_count(free_count)
    );

    fbfl_checker #(.MAX_BLOCKS(MAX_BLOCKS)) chk (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .kind(kind), .block_index(block_index),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .status(status), .free_block(free_block), .was_free(was_free),
        .used_count(used_count), .free_count(free_count),
        .errors(errors), .pending(pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[fixed_block_free_list_manager] ERROR");
        $finish;
    end

    // response pacing: a wait is drawn after every transfer
    initial
    begin : rx_pace
        int unsigned rx_wait;
        int unsigned rx_taken;
        rx_wait = 0;
        rx_taken = 0;
        pace_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                rx_taken++;
                if (rx_taken % 50 == 0)
                    rx_busy = ($urandom_range(0, 3) != 0);
                rx_wait = rx_busy ? $urandom_range(0, 12) : 0;
            end
            @(negedge clk);
            if (rx_wait > 0)
            begin
                pace_stall <= 1'b1;
                rx_wait--;
            end
            else
                pace_stall <= 1'b0;
        end
    end

    // long receiver hold-off so the block backs up into the request side
    initial
    begin : rx_hold
        hold_rsp = 1'b0;
        forever
        begin
            wait (hold_req);
            hold_req = 1'b0;
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_rsp <= 1'b0;
        end
    end

    function automatic int below_used();
        return (tx_used == 0) ? 0 : $urandom_range(0, tx_used - 1);
    endfunction

    function automatic int free_member();
        if (tx_free_q.size() == 0)
            return below_used();
        return tx_free_q[$urandom_range(0, tx_free_q.size() - 1)];
    endfunction

    // stimulus-side bookkeeping, only used to steer index choice
    function automatic void track_issue(input kind_t k, input int b);
        int hit;
        hit = -1;
        foreach (tx_free_q[i])
            if (tx_free_q[i] == b)
                hit = i;
        if (k == OP_WRITE && (b < tx_used || (b == tx_used && tx_used < MAX_BLOCKS)))
        begin
            if (hit >= 0)
                tx_free_q.delete(hit);
            if (b == tx_used)
                tx_used++;
        end
        else if (k == OP_DELETE && b < tx_used && hit < 0)
            tx_free_q.insert(tx_free_q.size(), b);
    endfunction

    function automatic void pick_item(output kind_t k, output int b);
        int r;
        int sub;
        r = $urandom_range(0, 99);
        sub = $urandom_range(0, 9);
        if (r < 8)
        begin
            k = kind_t'($urandom_range(0, 3));
            b = $urandom_range(0, BLK_SPAN - 1);
        end
        else if (r < 48)
        begin
            k = OP_WRITE;
            if (sub < 4)
                b = (tx_used < MAX_BLOCKS) ? tx_used : below_used();
            else if (sub < 7)
                b = free_member();
            else if (sub < 9)
                b = below_used();
            else
                b = $urandom_range(0, BLK_SPAN - 1);
        end
        else if (r < 63)
        begin
            k = OP_READ;
            b = (sub < 5) ? below_used() :
                (sub < 8) ? free_member() : $urandom_range(0, BLK_SPAN - 1);
        end
        else if (r < 85)
        begin
            k = OP_DELETE;
            b = (sub < 7) ? below_used() :
                (sub < 9) ? free_member() : $urandom_range(0, BLK_SPAN - 1);
        end
        else
        begin
            k = OP_GET_FREE;
            b = $urandom_range(0, BLK_SPAN - 1);
        end
    endfunction

    // entered and left at a falling edge; valid stays high across back-to-back items
    task automatic send_item(input kind_t k, input int b);
        int unsigned gap;
        if (n_sent % 40 == 0)
            tx_busy = ($urandom_range(0, 3) != 0);
        gap = tx_busy ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        kind <= k;
        block_index <= b[BLK_W-1:0];
        track_issue(k, b);
        do
            @(posedge clk);
        while (req_stall);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin : stim
        kind_t d_kind[N_DIRECTED];
        int    d_blk[N_DIRECTED];
        kind_t k;
        int    b;
        int    n_rand;
        d_kind = '{OP_GET_FREE, OP_READ, OP_DELETE, OP_WRITE, OP_WRITE,
                   OP_WRITE, OP_WRITE, OP_WRITE, OP_WRITE, OP_READ,
                   OP_READ, OP_DELETE, OP_DELETE, OP_READ, OP_DELETE,
                   OP_DELETE, OP_GET_FREE, OP_WRITE, OP_GET_FREE, OP_WRITE,
                   OP_GET_FREE, OP_WRITE, OP_WRITE, OP_READ, OP_DELETE};
        // empty list, nonexistent blocks, growth, double delete, removal from
        // the middle and the head of the list, top index
        d_blk = '{1023, 0, 0, 1, 0,
                  1, 2, 3, 0, 3,
                  4, 1, 1, 1, 3,
                  0, 0, 3, 1023, 1,
                  0, 0, 1023, 1023, 1023};
        rst_n = 1'b0;
        req_valid = 1'b0;
        kind = OP_WRITE;
        block_index = '0;
        hold_req = 1'b0;
        tx_busy = 1'b1;
        rx_busy = 1'b1;
        n_sent = 0;
        tx_used = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(d_kind[i], d_blk[i]);
        drain();

        n_rand = 0;
        for (int i = 0; i < 300; i++)
        begin
            if (i == 150)
                hold_req = 1'b1;
            pick_item(k, b);
            send_item(k, b);
            n_rand++;
        end
        drain();

        // grow the store to its full size with some mixed traffic in between
        while (tx_used < MAX_BLOCKS)
        begin
            if ($urandom_range(0, 4) == 0)
                pick_item(k, b);
            else
            begin
                k = OP_WRITE;
                b = tx_used;
            end
            send_item(k, b);
            n_rand++;
        end
        drain();

        hold_req = 1'b1;
        for (int i = 0; i < 300 || n_rand < RAND_ITEMS; i++)
        begin
            pick_item(k, b);
            send_item(k, b);
            n_rand++;
        end

        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("[fixed_block_free_list_manager] OK");
        else
            $display("[fixed_block_free_list_manager] ERROR");
        $finish;
    end

endmodule
